>>> rtl/htc_pkg.sv
`default_nettype none

package htc_pkg;

    localparam int NUM_ENT  = 6;
    localparam int ENT_MAX  = 6;
    localparam int HELD_MAX = 5;
    localparam int RES_MAX  = 7;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_cnt;

    typedef struct packed {
        t_byte data;
        logic  valid;
        logic  eot;
    } t_res;

    localparam t_byte CH_AMP  = 8'h26;
    localparam t_byte CH_LT   = 8'h3c;
    localparam t_byte CH_GT   = 8'h3e;
    localparam t_byte CH_SP   = 8'h20;
    localparam t_byte CH_TAB  = 8'h09;
    localparam t_byte CH_LF   = 8'h0a;
    localparam t_byte CH_CR   = 8'h0d;

    // &amp; &lt; &gt; &quot; &#x27; &#39;
    localparam t_byte ENT_PAT [NUM_ENT][ENT_MAX] = '{
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
        '{8'h26, 8'h23, 8'h78, 8'h32, 8'h37, 8'h3b},
        '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3b, 8'h00}
    };
    localparam t_cnt  ENT_LEN  [NUM_ENT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd5};
    localparam t_byte ENT_CHAR [NUM_ENT] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h27};

    function automatic logic is_ws(input t_byte b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

`default_nettype wire

>>> rtl/html_text_cleaner_top.sv
// The first result of an item is registered and offered in the cycle after its transfer.
// One item per cycle while each gives at most one result and the receiver is ready;
// an item with n results holds the single result buffer, one result per ready cycle.
// Reset: synchronous, active low; clears tag, entity and whitespace state and
// empties the result buffer. Held entity bytes are not cleared.
`default_nettype none

module html_text_cleaner_top
    import htc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire        s_axis_tlast,   // last
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] byte_valid
    output logic       m_axis_tlast    // end_of_text
);

    logic  r_in_tag, n_in_tag;
    t_byte r_held [HELD_MAX];
    t_cnt  r_hc, n_hc;
    logic  r_emitted, n_emitted;
    logic  r_owed, n_owed;

    t_res  r_buf [RES_MAX];
    t_cnt  r_cnt;
    t_res  n_list [RES_MAX];
    t_cnt  n_num;

    logic  acc, take;
    logic  wr_en;
    t_cnt  wr_idx;

    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tdata  = r_buf[0].data;
    assign m_axis_tuser  = r_buf[0].valid;
    assign m_axis_tlast  = r_buf[0].eot;
    assign take          = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && m_axis_tready);
    assign acc           = s_axis_tvalid && s_axis_tready;

    always_comb begin
        t_byte b;
        logic  last, ext, is_lt, is_gt, is_amp;
        logic  m_ok, any_full, any_pref;
        t_byte ent_c;
        t_cnt  nh;
        logic  x_on, x_ws, x_emit, sp;
        t_byte x;
        t_cnt  k, nbytes;

        b      = s_axis_tdata;
        last   = s_axis_tlast;
        ext    = (r_hc != 3'd0) && !r_in_tag;
        is_lt  = (b == CH_LT);
        is_gt  = (b == CH_GT);
        is_amp = (b == CH_AMP);

        any_full = 1'b0;
        any_pref = 1'b0;
        ent_c    = '0;
        // lowest entity wins on a full match
        for (int e = NUM_ENT - 1; e >= 0; e--) begin
            m_ok = 1'b1;
            for (int i = 0; i < HELD_MAX; i++) begin
                if ((3'(i) < r_hc) && (r_held[i] != ENT_PAT[e][i])) begin
                    m_ok = 1'b0;
                end
            end
            if (m_ok && (r_hc < ENT_LEN[e]) && (ENT_PAT[e][r_hc] == b)) begin
                if ((r_hc + 3'd1) == ENT_LEN[e]) begin
                    any_full = 1'b1;
                    ent_c    = ENT_CHAR[e];
                end else begin
                    any_pref = 1'b1;
                end
            end
        end

        nh       = 3'd0;
        x_on     = 1'b0;
        x        = b;
        n_in_tag = r_in_tag;
        n_hc     = r_hc;
        wr_en    = 1'b0;
        wr_idx   = 3'd0;

        if (ext && any_full) begin
            x_on = 1'b1;
            x    = ent_c;
            n_hc = 3'd0;
        end else if (ext && any_pref) begin
            n_hc   = r_hc + 3'd1;
            wr_en  = 1'b1;
            wr_idx = r_hc;
            if (last) begin
                nh   = r_hc;
                x_on = 1'b1;
            end
        end else begin
            // replay a broken entity, then treat the byte afresh
            if (ext) begin
                nh   = r_hc;
                n_hc = 3'd0;
            end
            if (is_lt) begin
                n_in_tag = 1'b1;
            end else if (is_gt) begin
                n_in_tag = 1'b0;
            end else if (r_in_tag) begin
                n_in_tag = 1'b1;
            end else if (is_amp) begin
                wr_en = 1'b1;
                n_hc  = 3'd1;
                x_on  = last;
            end else begin
                x_on = 1'b1;
            end
        end

        x_ws   = x_on && is_ws(x);
        x_emit = x_on && !x_ws;
        sp     = r_owed && ((nh != 3'd0) || x_emit);
        nbytes = nh + {2'b00, sp} + {2'b00, x_emit};

        for (int j = 0; j < RES_MAX; j++) begin
            n_list[j] = '{data: '0, valid: 1'b1, eot: 1'b0};
            k = 3'(j) - {2'b00, sp};
            if (sp && (j == 0)) begin
                n_list[j].data = CH_SP;
            end else if (k < nh) begin
                n_list[j].data = r_held[k];
            end else if ((k == nh) && x_emit) begin
                n_list[j].data = x;
            end
        end

        n_num     = nbytes;
        n_emitted = r_emitted || (nbytes != 3'd0);
        if (x_ws) begin
            n_owed = r_emitted || (nh != 3'd0) || r_owed;
        end else begin
            n_owed = (nbytes != 3'd0) ? 1'b0 : r_owed;
        end

        if (last) begin
            if (nbytes == 3'd0) begin
                n_list[0] = '{data: '0, valid: 1'b0, eot: 1'b1};
                n_num     = 3'd1;
            end else begin
                n_list[nbytes - 3'd1].eot = 1'b1;
            end
            n_in_tag  = 1'b0;
            n_hc      = 3'd0;
            n_emitted = 1'b0;
            n_owed    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag  <= 1'b0;
            r_hc      <= 3'd0;
            r_emitted <= 1'b0;
            r_owed    <= 1'b0;
            r_cnt     <= 3'd0;
        end else begin
            if (acc) begin
                r_in_tag  <= n_in_tag;
                r_hc      <= n_hc;
                r_emitted <= n_emitted;
                r_owed    <= n_owed;
                r_cnt     <= n_num;
            end else if (take) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && wr_en) begin
            r_held[wr_idx] <= s_axis_tdata;
        end
        if (acc) begin
            r_buf <= n_list;
        end else if (take) begin
            // advance the queue by one transfer
            for (int j = 0; j < RES_MAX - 1; j++) begin
                r_buf[j] <= r_buf[j + 1];
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import htc_pkg::*;

    localparam int    CYC_LIMIT   = 500_000;
    localparam int    HOLD_CYCLES = 300;
    localparam t_byte CH_QUOT     = 8'h22;
    localparam t_byte CH_APOS     = 8'h27;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;    // last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tuser;            // [0] byte_valid
    logic       m_axis_tlast;            // end_of_text

    html_text_cleaner_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // entity spellings and the characters they decode to
    string ent_txt  [NUM_ENT] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&#x27;", "&#39;"};
    t_byte ent_char [NUM_ENT] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS, CH_APOS};

    // cleaner state as predicted
    logic  in_tag;
    t_byte held [ENT_MAX];
    int    held_n;
    logic  seen_text;
    logic  space_due;

    t_res  clean_q [$];
    t_res  rx_want;
    t_byte text_buf [$];
    int    mism_cnt;
    int    cyc;
    logic  tx_steady;
    logic  rx_steady;
    int    hold_id;
    int    hold_seen;
    int    hold_left;
    int    stall_left;

    initial begin
        in_tag     = 1'b0;
        held_n     = 0;
        seen_text  = 1'b0;
        space_due  = 1'b0;
        mism_cnt   = 0;
        cyc        = 0;
        tx_steady  = 1'b0;
        rx_steady  = 1'b0;
        hold_id    = 0;
        hold_seen  = 0;
        hold_left  = 0;
        stall_left = 0;
    end

    function automatic logic blank_byte(input t_byte b);
        return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    // whitespace collapser: trim both ends, one space per inner run
    function automatic void put_clean(input t_byte b);
        if (blank_byte(b)) begin
            if (seen_text)
                space_due = 1'b1;
            return;
        end
        if (space_due) begin
            clean_q.push_back('{data: CH_SP, valid: 1'b1, eot: 1'b0});
            space_due = 1'b0;
        end
        clean_q.push_back('{data: b, valid: 1'b1, eot: 1'b0});
        seen_text = 1'b1;
    endfunction

    function automatic void replay_held();
        for (int i = 0; i < held_n; i++)
            put_clean(held[i]);
        held_n = 0;
    endfunction

    function automatic void take_raw(input t_byte b);
        if (b == CH_LT) begin
            in_tag = 1'b1;
            return;
        end
        if (b == CH_GT) begin
            in_tag = 1'b0;
            return;
        end
        if (in_tag)
            return;
        if (b == CH_AMP) begin
            held[0] = b;
            held_n  = 1;
            return;
        end
        put_clean(b);
    endfunction

    function automatic void grow_entity(input t_byte b);
        int   len;
        int   ln;
        logic prefix;
        logic same;
        len    = held_n + 1;
        prefix = 1'b0;
        held[held_n] = b;
        for (int e = 0; e < NUM_ENT; e++) begin
            ln = ent_txt[e].len();
            if (len > ln)
                continue;
            same = 1'b1;
            for (int k = 0; k < len; k++)
                if (held[k] != t_byte'(ent_txt[e][k]))
                    same = 1'b0;
            if (!same)
                continue;
            if (len == ln) begin
                held_n = 0;
                put_clean(ent_char[e]);
                return;
            end
            prefix = 1'b1;
        end
        if (prefix) begin
            held_n = len;
            return;
        end
        replay_held();
        take_raw(b);
    endfunction

    function automatic void clean_byte(input t_byte b, input logic fin);
        int base;
        base = clean_q.size();
        if (held_n > 0 && !in_tag)
            grow_entity(b);
        else
            take_raw(b);
        if (fin) begin
            replay_held();
            if (clean_q.size() > base)
                clean_q[$].eot = 1'b1;
            else
                clean_q.push_back('{data: 8'h00, valid: 1'b0, eot: 1'b1});
            in_tag    = 1'b0;
            held_n    = 0;
            seen_text = 1'b0;
            space_due = 1'b0;
        end
    endfunction

    function automatic int pick_gap(input logic steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_error(input string msg);
        $display("mismatch at cycle %0d: %s", cyc, msg);
        mism_cnt++;
    endtask

    task automatic send_byte(input t_byte b, input logic fin);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        clean_byte(b, fin);
    endtask

    // send the buffered string, last flag on its final byte
    task automatic send_buf();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf = {};
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(t_byte'(s[i]));
    endtask

    // hold the sender back until every predicted byte has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (clean_q.size() != 0);
    endtask

    task automatic add_token();
        int    e;
        int    n;
        t_byte b;
        case ($urandom_range(0, 7))
            0, 7: begin
                n = $urandom_range(1, 6);
                repeat (n) text_buf.push_back(t_byte'($urandom_range(8'h61, 8'h7a)));
            end
            1: begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: text_buf.push_back(CH_SP);
                        1: text_buf.push_back(CH_TAB);
                        2: text_buf.push_back(CH_LF);
                        default: text_buf.push_back(CH_CR);
                    endcase
                end
            end
            2: add_str(ent_txt[$urandom_range(0, NUM_ENT - 1)]);
            3: begin
                // cut an entity short, then break it
                e = $urandom_range(0, NUM_ENT - 1);
                n = $urandom_range(1, ent_txt[e].len() - 1);
                add_str(ent_txt[e].substr(0, n - 1));
                case ($urandom_range(0, 4))
                    0: text_buf.push_back(CH_LT);
                    1: text_buf.push_back(CH_AMP);
                    2: text_buf.push_back(CH_SP);
                    3: text_buf.push_back(CH_GT);
                    default: text_buf.push_back(t_byte'($urandom_range(1, 255)));
                endcase
            end
            4: begin
                text_buf.push_back(CH_LT);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    do b = t_byte'($urandom_range(1, 255)); while (b == CH_GT);
                    text_buf.push_back(b);
                end
                text_buf.push_back(CH_GT);
            end
            5: text_buf.push_back(CH_GT);
            default: text_buf.push_back(t_byte'($urandom_range(1, 255)));
        endcase
    endtask

    task automatic check_directed_text();
        add_str(" a&lt;&q<x>&#39\n b>&");
        send_buf();
        // whitespace only gives a bare end marker
        text_buf.push_back(CH_CR);
        send_buf();
        add_str("<q");
        send_buf();
        text_buf = '{8'h01, 8'hff};
        send_buf();
        add_str("z ");
        send_buf();
    endtask

    task automatic check_markup_stream(input int n_items);
        int sent;
        int ntok;
        sent = 0;
        while (sent < n_items) begin
            ntok = $urandom_range(1, 10);
            repeat (ntok) add_token();
            sent += text_buf.size();
            send_buf();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
            tx_steady = ($urandom_range(0, 5) == 0);
            rx_steady = ($urandom_range(0, 5) == 0);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // receiver stops for a long stretch while the sender keeps offering
    task automatic check_output_stall();
        hold_id  <= hold_id + 1;
        tx_steady = 1'b1;
        repeat (4) begin
            add_str("&quot");
            text_buf.push_back(CH_SP);
            add_token();
            add_str("&#x27;");
        end
        send_buf();
        tx_steady = 1'b0;
    endtask

    task automatic check_raw_noise(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_byte(t_byte'($urandom_range(1, 255)),
                      i == n_items - 1 || $urandom_range(0, 9) == 0);
    endtask

    always @(posedge i_clk) begin
        if (hold_id != hold_seen) begin
            hold_seen     <= hold_id;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_steady) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap(1'b0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (clean_q.size() == 0) begin
                flag_error($sformatf("unexpected transfer data %h user %b last %b",
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast));
            end else begin
                rx_want = clean_q.pop_front();
                if (m_axis_tdata !== rx_want.data || m_axis_tuser !== rx_want.valid
                        || m_axis_tlast !== rx_want.eot)
                    flag_error($sformatf("got %h/%b/%b, want %h/%b/%b",
                                         m_axis_tdata, m_axis_tuser, m_axis_tlast,
                                         rx_want.data, rx_want.valid, rx_want.eot));
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_directed_text();
        wait_drained();
        check_markup_stream(60);
        check_output_stall();
        check_raw_noise(40);
        check_markup_stream(20);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (clean_q.size() == 0 && mism_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/htc_pkg.sv
rtl/html_text_cleaner_top.sv
tb/testbench.sv
